// File: rtl/smmu_pkg.sv
// Shared types and constants of the segmented address translation unit.
`timescale 1ns / 1ps

package smmu_pkg;

    // Table geometry
    localparam int unsigned PAGES_PER_MODE = 8;
    localparam int unsigned NUM_SPACES     = 2;
    localparam int unsigned NUM_MODES      = 4;
    localparam int unsigned WORD_W         = 16;
    localparam int unsigned TABLE_DEPTH    = NUM_SPACES * NUM_MODES * PAGES_PER_MODE;

    // Address fields
    localparam int unsigned VA_W    = 16;
    localparam int unsigned PA_W    = 19;
    localparam int unsigned DISP_W  = 6;
    localparam int unsigned BLOCK_W = 7;
    localparam int unsigned PAGE_W  = 3;
    localparam int unsigned BASE_W  = 12;
    localparam int unsigned SUM_W   = PA_W - DISP_W;

    // I/O page relocation with translation off
    localparam logic [VA_W-1:0] IO_PAGE_START  = 16'o170000;
    localparam logic [PA_W-1:0] IO_PAGE_OFFSET = 19'o600000;

    // Descriptor bits
    localparam int unsigned DESC_READ_BIT  = 1;
    localparam int unsigned DESC_WRITE_BIT = 2;
    localparam int unsigned DESC_DOWN_BIT  = 3;
    localparam int unsigned DESC_WRITTEN   = 6;
    localparam int unsigned DESC_LEN_LSB   = 8;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_MMU_ENABLE = 1'b0;
    localparam logic        REG_DS_ENABLE  = 1'b1;

    typedef enum logic [1:0] {
        OP_FETCH  = 2'd0,
        OP_DATA   = 2'd1,
        OP_REG_WR = 2'd2,
        OP_REG_RD = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_KERNEL  = 2'd0,
        MODE_SUPER   = 2'd1,
        MODE_ILLEGAL = 2'd2,
        MODE_USER    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        FAULT_NONE   = 3'd0,
        FAULT_RDONLY = 3'd1,
        FAULT_NOACC  = 3'd2,
        FAULT_LENGTH = 3'd3,
        FAULT_BUS    = 3'd4
    } t_fault;

endpackage

// File: rtl/smmu_if.sv
// Request and response channel interfaces of the translation unit.
`timescale 1ns / 1ps

interface smmu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] virtual_address;
    logic        is_write;
    logic [1:0]  access_mode;
    logic [15:0] current_pc;
    logic        reg_space;
    logic        reg_kind;
    logic [2:0]  reg_page;
    logic [15:0] write_data;

    modport source (
        output valid, operation, virtual_address, is_write, access_mode, current_pc,
               reg_space, reg_kind, reg_page, write_data,
        input  ready
    );
    modport sink (
        input  valid, operation, virtual_address, is_write, access_mode, current_pc,
               reg_space, reg_kind, reg_page, write_data,
        output ready
    );
endinterface

interface smmu_rsp_if;
    logic        valid;
    logic        ready;
    logic [18:0] physical_address;
    logic [15:0] read_data;
    logic [2:0]  fault;
    logic [2:0]  abort_page;
    logic [1:0]  abort_mode;
    logic [15:0] error_pc;

    modport source (
        output valid, physical_address, read_data, fault, abort_page, abort_mode, error_pc,
        input  ready
    );
    modport sink (
        input  valid, physical_address, read_data, fault, abort_page, abort_mode, error_pc,
        output ready
    );
endinterface

// File: rtl/smmu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module smmu_ram #(
    parameter int unsigned WIDTH = smmu_pkg::WORD_W,
    parameter int unsigned DEPTH = smmu_pkg::TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/segmented_mmu_translate.sv
// Top level of the segmented address translation unit.
`timescale 1ns / 1ps

// Segmented address translation unit. Page address and page descriptor words for
// 2 spaces x 4 modes x PAGES_PER_MODE pages live in two synchronous RAMs. Each
// request (translate or page register access) is accepted in ST_IDLE, which issues
// the table read; ST_EXEC then checks permissions and length, writes back the
// descriptor (written bit or register write) and loads the response register.
// The response register lets the next request be accepted while a response waits;
// a full response register stalls ST_EXEC. A request is accepted only once the last
// has left ST_EXEC, for the read-modify-write of the table RAMs. After reset the
// tables read as zero through per-entry valid bits, so no clearing pass is needed.
// Configuration: byte address 0 is mmu_enable, 4 is data_space_enable; write only
// while the unit is idle.
module segmented_mmu_translate #(
    parameter int unsigned PAGES_PER_MODE = smmu_pkg::PAGES_PER_MODE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smmu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [smmu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [smmu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    smmu_req_if.sink                          i_req,
    smmu_rsp_if.source                        o_rsp
);

    localparam int unsigned ENTRIES = smmu_pkg::NUM_SPACES * smmu_pkg::NUM_MODES
                                      * PAGES_PER_MODE;
    localparam int unsigned IDX_W   = $clog2(ENTRIES);
    localparam int unsigned W       = smmu_pkg::WORD_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    // Control and configuration
    t_state                   r_state, n_state;
    logic                     r_mmu_enable;
    logic [2:0]               r_ds_enable;
    logic [ENTRIES-1:0]       r_base_vld, n_base_vld;
    logic [ENTRIES-1:0]       r_desc_vld, n_desc_vld;

    // Captured request
    smmu_pkg::t_op            r_op;
    logic [smmu_pkg::VA_W-1:0] r_va;
    logic                     r_wr;
    logic [1:0]               r_mode;
    logic [15:0]              r_pc;
    logic                     r_rkind;
    logic [15:0]              r_wdata;
    logic [IDX_W-1:0]         r_idx;

    // Abort record
    logic [2:0]               r_abort_page, n_abort_page;
    logic [1:0]               r_abort_mode, n_abort_mode;
    logic [15:0]              r_error_pc, n_error_pc;

    // Response register
    logic                     r_out_valid, n_out_valid;
    logic [smmu_pkg::PA_W-1:0] r_out_pa, n_out_pa;
    logic [W-1:0]             r_out_rd, n_out_rd;
    smmu_pkg::t_fault         r_out_fault, n_out_fault;

    logic                     w_accept;
    logic                     w_exec_go;
    logic                     w_space;
    logic [2:0]               w_page;
    logic [IDX_W-1:0]         w_idx;
    logic [W-1:0]             w_base_rd, w_desc_rd;
    logic [W-1:0]             w_base_q, w_desc_q;
    logic                     w_base_we, w_desc_we;
    logic [W-1:0]             w_base_wdata, w_desc_wdata;
    logic [smmu_pkg::BLOCK_W-1:0] w_block, w_len;
    smmu_pkg::t_fault         w_kind;
    logic [smmu_pkg::SUM_W-1:0] w_sum;
    logic                     w_cfg_wr;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mmu_enable <= 1'b0;
            r_ds_enable  <= 3'b000;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                smmu_pkg::REG_MMU_ENABLE: r_mmu_enable <= pwdata[0];
                smmu_pkg::REG_DS_ENABLE:  r_ds_enable  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            smmu_pkg::REG_MMU_ENABLE: prdata[0]   = r_mmu_enable;
            smmu_pkg::REG_DS_ENABLE:  prdata[2:0] = r_ds_enable;
            default: prdata = '0;
        endcase
    end

    // Accept one request at a time
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && (r_state == ST_IDLE);
    assign w_exec_go   = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);

    // Pick the table space for the incoming request
    always_comb begin
        w_space = 1'b0;
        if (i_req.operation == smmu_pkg::OP_REG_WR || i_req.operation == smmu_pkg::OP_REG_RD) begin
            w_space = i_req.reg_space;
        end else if (i_req.operation == smmu_pkg::OP_DATA) begin
            case (smmu_pkg::t_mode'(i_req.access_mode))
                smmu_pkg::MODE_ILLEGAL: w_space = 1'b1;
                smmu_pkg::MODE_USER:    w_space = r_ds_enable[0];
                smmu_pkg::MODE_SUPER:   w_space = r_ds_enable[1];
                smmu_pkg::MODE_KERNEL:  w_space = r_ds_enable[2];
                default:                w_space = 1'b0;
            endcase
        end
    end

    // Form the table index: space, mode, page
    always_comb begin
        if (i_req.operation == smmu_pkg::OP_REG_WR || i_req.operation == smmu_pkg::OP_REG_RD) begin
            w_page = i_req.reg_page;
        end else begin
            w_page = i_req.virtual_address[15:13];
        end
        w_idx = IDX_W'(32'(w_space) * smmu_pkg::NUM_MODES * PAGES_PER_MODE
                       + 32'(i_req.access_mode) * PAGES_PER_MODE
                       + 32'(w_page) % PAGES_PER_MODE);
    end

    // Capture the request at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= smmu_pkg::t_op'(i_req.operation);
            r_va    <= i_req.virtual_address;
            r_wr    <= i_req.is_write;
            r_mode  <= i_req.access_mode;
            r_pc    <= i_req.current_pc;
            r_rkind <= i_req.reg_kind;
            r_wdata <= i_req.write_data;
            r_idx   <= w_idx;
        end
    end

    // Page tables
    smmu_ram #(.WIDTH(W), .DEPTH(ENTRIES)) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (w_base_we),
        .i_waddr (r_idx),
        .i_wdata (w_base_wdata),
        .i_re    (w_accept),
        .i_raddr (w_idx),
        .o_rdata (w_base_rd)
    );

    smmu_ram #(.WIDTH(W), .DEPTH(ENTRIES)) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (w_desc_we),
        .i_waddr (r_idx),
        .i_wdata (w_desc_wdata),
        .i_re    (w_accept),
        .i_raddr (w_idx),
        .o_rdata (w_desc_rd)
    );

    // Entries never written read as zero
    assign w_base_q = r_base_vld[r_idx] ? w_base_rd : '0;
    assign w_desc_q = r_desc_vld[r_idx] ? w_desc_rd : '0;

    // Permission and length checks, in priority order
    assign w_block = r_va[smmu_pkg::DISP_W +: smmu_pkg::BLOCK_W];
    assign w_len   = w_desc_q[smmu_pkg::DESC_LEN_LSB +: smmu_pkg::BLOCK_W];
    assign w_sum   = smmu_pkg::SUM_W'(w_block)
                   + smmu_pkg::SUM_W'(w_base_q[smmu_pkg::BASE_W-1:0]);

    always_comb begin
        w_kind = smmu_pkg::FAULT_NONE;
        if (r_wr && !(w_desc_q[smmu_pkg::DESC_READ_BIT] && w_desc_q[smmu_pkg::DESC_WRITE_BIT])) begin
            w_kind = smmu_pkg::FAULT_RDONLY;
        end else if (!w_desc_q[smmu_pkg::DESC_READ_BIT]) begin
            w_kind = smmu_pkg::FAULT_NOACC;
        end else if (w_desc_q[smmu_pkg::DESC_DOWN_BIT] ? (w_block < w_len) : (w_block > w_len)) begin
            w_kind = smmu_pkg::FAULT_LENGTH;
        end
    end

    // Execute: build the response, update tables and abort record
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_pa     = r_out_pa;
        n_out_rd     = r_out_rd;
        n_out_fault  = r_out_fault;
        n_abort_page = r_abort_page;
        n_abort_mode = r_abort_mode;
        n_error_pc   = r_error_pc;
        n_base_vld   = r_base_vld;
        n_desc_vld   = r_desc_vld;
        w_base_we    = 1'b0;
        w_desc_we    = 1'b0;
        w_base_wdata = r_wdata;
        w_desc_wdata = w_desc_q;

        // Drop the response once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_exec_go) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_pa    = '0;
                    n_out_rd    = '0;
                    n_out_fault = smmu_pkg::FAULT_NONE;
                    case (r_op)
                        smmu_pkg::OP_FETCH, smmu_pkg::OP_DATA: begin
                            if (!r_mmu_enable) begin
                                if (r_va >= smmu_pkg::IO_PAGE_START) begin
                                    n_out_pa = smmu_pkg::PA_W'(r_va) + smmu_pkg::IO_PAGE_OFFSET;
                                end else begin
                                    n_out_pa = smmu_pkg::PA_W'(r_va);
                                end
                            end else if (w_kind != smmu_pkg::FAULT_NONE) begin
                                n_out_fault  = w_kind;
                                n_abort_page = r_va[15:13];
                                n_abort_mode = r_mode;
                                n_error_pc   = r_pc;
                            end else begin
                                n_out_pa = {w_sum, r_va[smmu_pkg::DISP_W-1:0]};
                                if (r_wr) begin
                                    w_desc_we = 1'b1;
                                    w_desc_wdata = w_desc_q;
                                    w_desc_wdata[smmu_pkg::DESC_WRITTEN] = 1'b1;
                                    n_desc_vld[r_idx] = 1'b1;
                                end
                            end
                        end
                        smmu_pkg::OP_REG_WR: begin
                            if (r_mode == smmu_pkg::MODE_ILLEGAL) begin
                                n_out_fault = smmu_pkg::FAULT_BUS;
                            end else begin
                                // Either word written clears the written bit
                                w_desc_we = 1'b1;
                                n_desc_vld[r_idx] = 1'b1;
                                w_desc_wdata = r_rkind ? r_wdata : w_desc_q;
                                w_desc_wdata[smmu_pkg::DESC_WRITTEN] = 1'b0;
                                if (!r_rkind) begin
                                    w_base_we = 1'b1;
                                    n_base_vld[r_idx] = 1'b1;
                                end
                            end
                        end
                        smmu_pkg::OP_REG_RD: begin
                            if (r_mode == smmu_pkg::MODE_ILLEGAL) begin
                                n_out_fault = smmu_pkg::FAULT_BUS;
                            end else begin
                                n_out_rd = r_rkind ? w_desc_q : w_base_q;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_base_vld   <= '0;
            r_desc_vld   <= '0;
            r_abort_page <= '0;
            r_abort_mode <= '0;
            r_error_pc   <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_base_vld   <= n_base_vld;
            r_desc_vld   <= n_desc_vld;
            r_abort_page <= n_abort_page;
            r_abort_mode <= n_abort_mode;
            r_error_pc   <= n_error_pc;
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        r_out_pa    <= n_out_pa;
        r_out_rd    <= n_out_rd;
        r_out_fault <= n_out_fault;
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.physical_address = r_out_pa;
    assign o_rsp.read_data        = r_out_rd;
    assign o_rsp.fault            = r_out_fault;
    assign o_rsp.abort_page       = r_abort_page;
    assign o_rsp.abort_mode       = r_abort_mode;
    assign o_rsp.error_pc         = r_error_pc;

endmodule
